FILE: rtl/cta_pkg.sv
`timescale 1ns / 1ps

package cta_pkg;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_MOD = 4'd4;
    localparam logic [3:0] OP_EQ  = 4'd5;
    localparam logic [3:0] OP_NE  = 4'd6;
    localparam logic [3:0] OP_LT  = 4'd7;
    localparam logic [3:0] OP_LE  = 4'd8;
    localparam logic [3:0] OP_GT  = 4'd9;
    localparam logic [3:0] OP_GE  = 4'd10;
    localparam logic [3:0] OP_AND = 4'd11;
    localparam logic [3:0] OP_OR  = 4'd12;

    localparam logic [1:0] KIND_SIGNED   = 2'd0;
    localparam logic [1:0] KIND_UNSIGNED = 2'd1;
    localparam logic [1:0] KIND_BOOL     = 2'd2;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_LOGIC     = 3'd1;
    localparam logic [2:0] ERR_COMPARE   = 3'd2;
    localparam logic [2:0] ERR_NOT_INT   = 3'd3;
    localparam logic [2:0] ERR_MIXED_NEG = 3'd4;
    localparam logic [2:0] ERR_DIV_ZERO  = 3'd5;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd6;
    localparam logic [2:0] ERR_UNDERFLOW = 3'd7;

    localparam int DIV_STEPS = 64;
    localparam int LATENCY   = DIV_STEPS + 4;

    typedef struct packed {
        logic [3:0]  op;
        logic [63:0] left_value;
        logic [1:0]  left_kind;
        logic [63:0] right_value;
        logic [1:0]  right_kind;
    } t_in;

    typedef struct packed {
        logic [63:0] result_value;
        logic [1:0]  result_kind;
        logic [2:0]  error_code;
    } t_out;

    typedef struct packed {
        logic [3:0]  op;
        logic [2:0]  err;
        logic        umode;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] xa;
        logic [63:0] xb;
        logic        neg_q;
        logic        neg_r;
    } t_dec;

    typedef struct packed {
        t_dec        dec;
        logic [63:0] prod_lo;
        logic        prod_hi_nz;
    } t_mul;

endpackage

FILE: rtl/cta_decode.sv
`timescale 1ns / 1ps

module cta_decode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  cta_pkg::t_in  i_item,
    output logic          o_valid,
    output cta_pkg::t_dec o_dec
);

    logic          r_valid;
    cta_pkg::t_dec r_dec;
    cta_pkg::t_dec n_dec;

    logic a_int, b_int, is_cmp, is_logic, mixed_neg, umode;
    logic [63:0] a, b;
    logic [1:0]  ka, kb;
    logic [3:0]  op;

    always_comb begin
        op = i_item.op;
        a  = i_item.left_value;
        b  = i_item.right_value;
        ka = i_item.left_kind;
        kb = i_item.right_kind;
        a_int = (ka == cta_pkg::KIND_SIGNED) || (ka == cta_pkg::KIND_UNSIGNED);
        b_int = (kb == cta_pkg::KIND_SIGNED) || (kb == cta_pkg::KIND_UNSIGNED);
        is_cmp = (op >= cta_pkg::OP_EQ) && (op <= cta_pkg::OP_GE);
        is_logic = (op == cta_pkg::OP_AND) || (op == cta_pkg::OP_OR);
        mixed_neg = (ka != kb) && ((ka == cta_pkg::KIND_SIGNED) ? a[63] : b[63]);
        umode = !((ka == cta_pkg::KIND_SIGNED) && (kb == cta_pkg::KIND_SIGNED));

        n_dec.op    = op;
        n_dec.umode = umode;
        n_dec.a     = a;
        n_dec.b     = b;
        n_dec.xa    = (!umode && a[63]) ? (~a + 64'd1) : a;
        n_dec.xb    = (!umode && b[63]) ? (~b + 64'd1) : b;
        n_dec.neg_q = !umode && (a[63] ^ b[63]);
        n_dec.neg_r = !umode && a[63];
        n_dec.err   = cta_pkg::ERR_OK;
        priority if (is_logic) begin
            if (ka != cta_pkg::KIND_BOOL || kb != cta_pkg::KIND_BOOL) begin
                n_dec.err = cta_pkg::ERR_LOGIC;
            end
        end else if (is_cmp && !(a_int && b_int)) begin
            n_dec.err = cta_pkg::ERR_COMPARE;
        end else if (!(a_int && b_int)) begin
            n_dec.err = cta_pkg::ERR_NOT_INT;
        end else if (mixed_neg) begin
            n_dec.err = cta_pkg::ERR_MIXED_NEG;
        end else if (op > cta_pkg::OP_OR) begin
            n_dec.err = cta_pkg::ERR_NOT_INT;
        end else if ((op == cta_pkg::OP_DIV || op == cta_pkg::OP_MOD) && b == 64'd0) begin
            n_dec.err = cta_pkg::ERR_DIV_ZERO;
        end else if (!umode && op == cta_pkg::OP_DIV && a == {1'b1, 63'd0} && b == '1) begin
            n_dec.err = cta_pkg::ERR_OVERFLOW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_dec <= n_dec;
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;

endmodule

FILE: rtl/cta_mul.sv
`timescale 1ns / 1ps

module cta_mul (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  cta_pkg::t_dec i_dec,
    output logic          o_valid,
    output cta_pkg::t_mul o_mul
);

    logic          r_va, r_vb;
    cta_pkg::t_dec r_dec_a;
    logic [63:0]   r_p0, r_p1, r_p2, r_p3;
    cta_pkg::t_mul r_mul;
    logic [64:0]   mid;
    logic [127:0]  n_prod;

    always_comb begin
        mid    = {1'b0, r_p1} + {1'b0, r_p2};
        n_prod = {64'd0, r_p0} + ({63'd0, mid} << 32) + {r_p3, 64'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
        r_dec_a <= i_dec;
        r_p0 <= {32'd0, i_dec.xa[31:0]}  * {32'd0, i_dec.xb[31:0]};
        r_p1 <= {32'd0, i_dec.xa[31:0]}  * {32'd0, i_dec.xb[63:32]};
        r_p2 <= {32'd0, i_dec.xa[63:32]} * {32'd0, i_dec.xb[31:0]};
        r_p3 <= {32'd0, i_dec.xa[63:32]} * {32'd0, i_dec.xb[63:32]};
        r_mul.dec        <= r_dec_a;
        r_mul.prod_lo    <= n_prod[63:0];
        r_mul.prod_hi_nz <= |n_prod[127:64];
    end

    assign o_valid = r_vb;
    assign o_mul   = r_mul;

endmodule

FILE: rtl/cta_divider.sv
`timescale 1ns / 1ps

module cta_divider (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  cta_pkg::t_mul i_mul,
    output logic          o_valid,
    output cta_pkg::t_mul o_mul,
    output logic [63:0]   o_quo,
    output logic [63:0]   o_rem
);

    localparam int N = cta_pkg::DIV_STEPS;

    logic          r_v   [0:N-1];
    cta_pkg::t_mul r_pl  [0:N-1];
    logic [63:0]   r_rem [0:N-1];
    logic [63:0]   r_quo [0:N-1];

    for (genvar i = 0; i < N; i++) begin : g_step
        logic          s_v;
        cta_pkg::t_mul s_pl;
        logic [63:0]   s_rem, s_quo;
        logic [64:0]   shifted, diff;
        logic [63:0]   n_rem, n_quo;

        if (i == 0) begin : g_first
            assign s_v   = i_valid;
            assign s_pl  = i_mul;
            assign s_rem = 64'd0;
            assign s_quo = i_mul.dec.xa;
        end else begin : g_next
            assign s_v   = r_v[i-1];
            assign s_pl  = r_pl[i-1];
            assign s_rem = r_rem[i-1];
            assign s_quo = r_quo[i-1];
        end

        always_comb begin
            shifted = {s_rem, s_quo[63]};
            diff    = shifted - {1'b0, s_pl.dec.xb};
            n_rem   = diff[64] ? shifted[63:0] : diff[63:0];
            n_quo   = {s_quo[62:0], ~diff[64]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else begin
                r_v[i] <= s_v;
            end
            r_pl[i]  <= s_pl;
            r_rem[i] <= n_rem;
            r_quo[i] <= n_quo;
        end
    end

    assign o_valid = r_v[N-1];
    assign o_mul   = r_pl[N-1];
    assign o_quo   = r_quo[N-1];
    assign o_rem   = r_rem[N-1];

endmodule

FILE: rtl/cta_final.sv
`timescale 1ns / 1ps

module cta_final (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  cta_pkg::t_mul i_mul,
    input  logic [63:0]   i_quo,
    input  logic [63:0]   i_rem,
    output logic          o_valid,
    output cta_pkg::t_out o_result
);

    logic          r_valid;
    cta_pkg::t_out r_res;
    cta_pkg::t_out n_res;

    cta_pkg::t_dec d;
    logic [64:0]   sum, dif;
    logic          lt, eq, r_bool, num_ok;
    logic [63:0]   val, lo;
    logic [2:0]    err;
    logic [1:0]    nkind;

    always_comb begin
        d   = i_mul.dec;
        lo  = i_mul.prod_lo;
        sum = {1'b0, d.a} + {1'b0, d.b};
        dif = {1'b0, d.a} - {1'b0, d.b};
        eq  = d.a == d.b;
        lt  = d.umode ? dif[64] : ($signed(d.a) < $signed(d.b));
        nkind  = d.umode ? cta_pkg::KIND_UNSIGNED : cta_pkg::KIND_SIGNED;
        err    = d.err;
        val    = 64'd0;
        r_bool = 1'b0;
        num_ok = 1'b1;
        unique case (d.op)
            cta_pkg::OP_ADD: begin
                val = sum[63:0];
                if (d.umode) begin
                    num_ok = !sum[64];
                end else begin
                    num_ok = !((d.a[63] == d.b[63]) && (sum[63] != d.a[63]));
                end
                if (!num_ok) err = cta_pkg::ERR_OVERFLOW;
            end
            cta_pkg::OP_SUB: begin
                val = dif[63:0];
                if (d.umode) begin
                    if (dif[64]) err = cta_pkg::ERR_UNDERFLOW;
                end else if ((d.a[63] != d.b[63]) && (dif[63] != d.a[63])) begin
                    err = cta_pkg::ERR_OVERFLOW;
                end
            end
            cta_pkg::OP_MUL: begin
                val = d.neg_q ? (~lo + 64'd1) : lo;
                if (d.umode) begin
                    num_ok = !i_mul.prod_hi_nz;
                end else begin
                    num_ok = !i_mul.prod_hi_nz &&
                             !(d.neg_q ? (lo > {1'b1, 63'd0}) : lo[63]);
                end
                if (!num_ok) err = cta_pkg::ERR_OVERFLOW;
            end
            cta_pkg::OP_DIV: val = d.neg_q ? (~i_quo + 64'd1) : i_quo;
            cta_pkg::OP_MOD: val = d.neg_r ? (~i_rem + 64'd1) : i_rem;
            cta_pkg::OP_EQ:  r_bool = eq;
            cta_pkg::OP_NE:  r_bool = !eq;
            cta_pkg::OP_LT:  r_bool = lt;
            cta_pkg::OP_LE:  r_bool = lt || eq;
            cta_pkg::OP_GT:  r_bool = !(lt || eq);
            cta_pkg::OP_GE:  r_bool = !lt;
            cta_pkg::OP_AND: r_bool = d.a[0] && d.b[0];
            cta_pkg::OP_OR:  r_bool = d.a[0] || d.b[0];
            default:         r_bool = 1'b0;
        endcase
        // operand check errors win over arithmetic errors
        if (d.err != cta_pkg::ERR_OK) err = d.err;
        if (d.op >= cta_pkg::OP_EQ) begin
            n_res.result_value = {63'd0, r_bool};
            n_res.result_kind  = cta_pkg::KIND_BOOL;
        end else begin
            n_res.result_value = val;
            n_res.result_kind  = nkind;
        end
        n_res.error_code = err;
        if (err != cta_pkg::ERR_OK) begin
            n_res.result_value = 64'd0;
            n_res.result_kind  = cta_pkg::KIND_SIGNED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_res <= n_res;
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

FILE: rtl/checked_typed_binary_alu.sv
`timescale 1ns / 1ps

// Checked 64-bit integer ALU for tagged operands. One beat is taken every
// cycle (o_busy stays low); each result appears on o_result with o_valid
// high for one cycle, in order. There is no way to hold a result off: the
// receiver must take it in that cycle. The pipeline is built around the
// 64-stage restoring divider, one quotient bit per stage; decode, two
// multiplier stages and the output stage add four more stages.

module checked_typed_binary_alu (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  cta_pkg::t_in  i_item,
    output logic          o_busy,
    output logic          o_valid,
    output cta_pkg::t_out o_result
);

    logic          dec_v, mul_v, div_v;
    cta_pkg::t_dec dec;
    cta_pkg::t_mul mul, div_pl;
    logic [63:0]   quo, rem;

    assign o_busy = 1'b0;

    cta_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start && !o_busy),
        .i_item  (i_item),
        .o_valid (dec_v),
        .o_dec   (dec)
    );

    cta_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_v),
        .i_dec   (dec),
        .o_valid (mul_v),
        .o_mul   (mul)
    );

    cta_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_v),
        .i_mul   (mul),
        .o_valid (div_v),
        .o_mul   (div_pl),
        .o_quo   (quo),
        .o_rem   (rem)
    );

    cta_final u_final (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (div_v),
        .i_mul    (div_pl),
        .i_quo    (quo),
        .i_rem    (rem),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##(cta_pkg::LATENCY) o_valid)
        else $error("result beat missing");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.error_code != cta_pkg::ERR_OK |->
        o_result.result_value == 64'd0 && o_result.result_kind == cta_pkg::KIND_SIGNED)
        else $error("error beat carries data");

    a_bool_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.result_kind == cta_pkg::KIND_BOOL |->
        o_result.result_value[63:1] == 63'd0)
        else $error("boolean result wider than one bit");

endmodule

FILE: bench/checked_typed_binary_alu_tb.sv
`timescale 1ns / 1ps

module checked_typed_binary_alu_tb;
    import cta_pkg::*;

    localparam longint CYCLE_LIMIT = 200000;
    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;

    class alu_scoreboard;
        t_out pending_q[$];
        int   mismatches;

        function t_out fail_with(logic [2:0] e);
            t_out r;
            r.result_value = '0;
            r.result_kind  = KIND_SIGNED;
            r.error_code   = e;
            return r;
        endfunction

        function t_out ok_with(logic [63:0] v, logic [1:0] k);
            t_out r;
            r.result_value = v;
            r.result_kind  = k;
            r.error_code   = ERR_OK;
            return r;
        endfunction

        function t_out evaluate(t_in it);
            logic [3:0]   op;
            logic [63:0]  a;
            logic [63:0]  b;
            logic         a_int;
            logic         b_int;
            logic         umode;
            logic         rel;
            logic [127:0] wide;
            logic [63:0]  ma;
            logic [63:0]  mb;
            logic         neg;
            longint       sa;
            longint       sb;
            op = it.op;
            a = it.left_value;
            b = it.right_value;
            a_int = it.left_kind == KIND_SIGNED || it.left_kind == KIND_UNSIGNED;
            b_int = it.right_kind == KIND_SIGNED || it.right_kind == KIND_UNSIGNED;
            if (op == OP_AND || op == OP_OR) begin
                if (it.left_kind != KIND_BOOL || it.right_kind != KIND_BOOL)
                    return fail_with(ERR_LOGIC);
                rel = (op == OP_AND) ? (a[0] & b[0]) : (a[0] | b[0]);
                return ok_with({63'd0, rel}, KIND_BOOL);
            end
            if (op >= OP_EQ && op <= OP_GE && !(a_int && b_int))
                return fail_with(ERR_COMPARE);
            if (!(a_int && b_int))
                return fail_with(ERR_NOT_INT);
            if (it.left_kind != it.right_kind) begin
                if ((it.left_kind == KIND_SIGNED) ? a[63] : b[63])
                    return fail_with(ERR_MIXED_NEG);
            end
            umode = !(it.left_kind == KIND_SIGNED && it.right_kind == KIND_SIGNED);
            sa = a;
            sb = b;
            if (op >= OP_EQ && op <= OP_GE) begin
                case (op)
                    OP_EQ: rel = a == b;
                    OP_NE: rel = a != b;
                    OP_LT: rel = umode ? a < b : sa < sb;
                    OP_LE: rel = umode ? a <= b : sa <= sb;
                    OP_GT: rel = umode ? a > b : sa > sb;
                    default: rel = umode ? a >= b : sa >= sb;
                endcase
                return ok_with({63'd0, rel}, KIND_BOOL);
            end
            if (op > OP_MOD)
                return fail_with(ERR_NOT_INT);
            if ((op == OP_DIV || op == OP_MOD) && b == 0)
                return fail_with(ERR_DIV_ZERO);
            if (!umode) begin
                case (op)
                    OP_ADD: begin
                        wide[63:0] = a + b;
                        if (a[63] == b[63] && wide[63] != a[63])
                            return fail_with(ERR_OVERFLOW);
                        return ok_with(wide[63:0], KIND_SIGNED);
                    end
                    OP_SUB: begin
                        wide[63:0] = a - b;
                        if (a[63] != b[63] && wide[63] != a[63])
                            return fail_with(ERR_OVERFLOW);
                        return ok_with(wide[63:0], KIND_SIGNED);
                    end
                    OP_MUL: begin
                        ma = a[63] ? -a : a;
                        mb = b[63] ? -b : b;
                        neg = a[63] ^ b[63];
                        if (ma == 0 || mb == 0)
                            return ok_with('0, KIND_SIGNED);
                        wide = {64'd0, ma} * {64'd0, mb};
                        if (wide[127:64] != 0 || (neg ? wide[63:0] > SMIN : wide[63:0] > SMAX))
                            return fail_with(ERR_OVERFLOW);
                        return ok_with(neg ? -wide[63:0] : wide[63:0], KIND_SIGNED);
                    end
                    default: begin
                        if (a == SMIN && b == ALL1)
                            return (op == OP_DIV) ? fail_with(ERR_OVERFLOW)
                                                  : ok_with('0, KIND_SIGNED);
                        if (op == OP_DIV)
                            return ok_with(sa / sb, KIND_SIGNED);
                        return ok_with(sa % sb, KIND_SIGNED);
                    end
                endcase
            end
            case (op)
                OP_ADD: begin
                    wide = {64'd0, a} + {64'd0, b};
                    if (wide[64]) return fail_with(ERR_OVERFLOW);
                    return ok_with(wide[63:0], KIND_UNSIGNED);
                end
                OP_SUB: begin
                    if (b > a) return fail_with(ERR_UNDERFLOW);
                    return ok_with(a - b, KIND_UNSIGNED);
                end
                OP_MUL: begin
                    wide = {64'd0, a} * {64'd0, b};
                    if (wide[127:64] != 0) return fail_with(ERR_OVERFLOW);
                    return ok_with(wide[63:0], KIND_UNSIGNED);
                end
                OP_DIV: return ok_with(a / b, KIND_UNSIGNED);
                default: return ok_with(a % b, KIND_UNSIGNED);
            endcase
        endfunction

        function void note_beat(t_in it);
            pending_q.push_back(evaluate(it));
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h/%0d/%0d", got.result_value,
                             got.result_kind, got.error_code);
                return;
            end
            want = pending_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                             want.result_value, want.result_kind, want.error_code,
                             got.result_value, got.result_kind, got.error_code);
            end
        endfunction
    endclass

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_start = 1'b0;
    t_in    i_item = '0;
    logic   o_busy;
    logic   o_valid;
    t_out   o_result;
    longint cycles = 0;
    alu_scoreboard board = new();

    checked_typed_binary_alu dut (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid)
            board.check_result(o_result);
        if (i_rst_n && i_start && !o_busy)
            board.note_beat(i_item);
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 64'd1;
            2: return ALL1;
            3: return SMIN;
            4: return SMAX;
            5: return {$urandom, $urandom};
            6: return 64'($urandom_range(0, 20));
            7: return -64'($urandom_range(1, 20));
            8: return {32'd0, $urandom};
            default: return {{32{1'b1}}, $urandom};
        endcase
    endfunction

    // one beat; holds start across back-to-back items
    task automatic send_beat(t_in it, bit allow_gap);
        while (allow_gap && $urandom_range(0, 99) < 34) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_parts(logic [3:0] op, logic [63:0] a, logic [1:0] ak,
                              logic [63:0] b, logic [1:0] bk);
        t_in it;
        it.op = op;
        it.left_value = a;
        it.left_kind = ak;
        it.right_value = b;
        it.right_kind = bk;
        send_beat(it, 1'b0);
    endtask

    initial begin
        t_in it;
        int  waited;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int op = 0; op < 16; op++)
            send_parts(op[3:0], SMAX, KIND_SIGNED, 64'd3, KIND_SIGNED);
        send_parts(OP_DIV, SMIN, KIND_SIGNED, ALL1, KIND_SIGNED);
        send_parts(OP_MOD, SMIN, KIND_SIGNED, ALL1, KIND_SIGNED);
        send_parts(OP_DIV, ALL1, KIND_UNSIGNED, 64'd0, KIND_UNSIGNED);
        send_parts(OP_SUB, 64'd0, KIND_UNSIGNED, ALL1, KIND_UNSIGNED);
        send_parts(OP_ADD, ALL1, KIND_UNSIGNED, ALL1, KIND_UNSIGNED);
        send_parts(OP_MUL, SMIN, KIND_SIGNED, 64'd1, KIND_SIGNED);
        send_parts(OP_LT, ALL1, KIND_SIGNED, 64'd1, KIND_UNSIGNED);
        send_parts(OP_AND, ALL1, KIND_BOOL, ALL1, KIND_BOOL);
        send_parts(OP_GE, 64'd1, 2'd3, 64'd1, KIND_SIGNED);
        for (int n = 0; n < 1000; n++) begin
            it.op = (n % 5 == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 12));
            it.left_value = pick_value();
            it.right_value = pick_value();
            if ($urandom_range(0, 9) == 0) begin
                it.left_kind = 2'($urandom);
                it.right_kind = 2'($urandom);
            end else if (it.op == OP_AND || it.op == OP_OR) begin
                it.left_kind = KIND_BOOL;
                it.right_kind = KIND_BOOL;
            end else begin
                it.left_kind = 2'($urandom_range(0, 1));
                it.right_kind = 2'($urandom_range(0, 1));
            end
            send_beat(it, n < 300 || n >= 500);
        end
        i_start <= 1'b0;
        waited = 0;
        while (board.pending_q.size() != 0 && waited < 10 * LATENCY) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/cta_pkg.sv
rtl/cta_decode.sv
rtl/cta_mul.sv
rtl/cta_divider.sv
rtl/cta_final.sv
rtl/checked_typed_binary_alu.sv
bench/checked_typed_binary_alu_tb.sv
